### hw/rtl/mcant_pkg.sv
// mcant_pkg: shared codes, register indexes and reset values for the
// multicolour ant step core. No dependencies.

package mcant_pkg;

    // Field widths fixed by the register map
    localparam int CFG_DIM_W   = 9;
    localparam int CFG_CNT_W   = 5;
    localparam int CFG_RULE_W  = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int COLOR_W     = 4;
    localparam int COUNT_W     = 32;

    // Clamping limits
    localparam int DIM_MIN     = 10;
    localparam int COLORS_MIN  = 2;
    localparam int MAX_COLORS  = 16;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0]  GRID_W_RST   = 9'd100;
    localparam logic [CFG_DIM_W-1:0]  GRID_H_RST   = 9'd100;
    localparam logic [CFG_CNT_W-1:0]  COLOR_CNT_RST = 5'd2;
    localparam logic [CFG_RULE_W-1:0] TURN_RULES_RST = 32'd13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RULES  = 4'd3;

    // Operation codes
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Headings
    typedef logic [1:0] t_heading;
    localparam t_heading HEAD_UP    = 2'd0;
    localparam t_heading HEAD_RIGHT = 2'd1;
    localparam t_heading HEAD_DOWN  = 2'd2;
    localparam t_heading HEAD_LEFT  = 2'd3;

endpackage

### hw/rtl/mcant_ram.sv
// mcant_ram: single-port-write, single-port-read synchronous memory holding
// the grid colours. Read data is registered. No dependencies.

module mcant_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [0:(2**ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/multicolor_ant_automaton_step_core.sv
// multicolor_ant_automaton_step_core: top level of the multicolour ant
// (turmite) stepper. Depends on mcant_pkg and mcant_ram.
//
// Every operation reads the cell colour from the registered grid memory in
// the cycle after its address is presented; the recoloured cell is written
// back at the edge that registers the result. Busy is high from each accepted
// start until the result is registered. A step (operation 0) moves the ant
// unless it has halted at the grid edge; a read (operation 1) returns the
// colour of any cell, 0 if outside the grid in use. The result is shown for
// exactly one cycle with o_done high and cannot be held off. After reset
// the grid memory, 2^(2*ceil(log2(MAX_DIM))) cells (65536 at the default
// size), is cleared one cell per cycle with busy high; configuration writes
// are taken at any time but are only meaningful while the core is not busy.
// Writing the grid width or height re-centres the ant on that axis.

module multicolor_ant_automaton_step_core #(
    parameter int MAX_DIM = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_operation,
    input  logic [7:0]                        i_cell_x,
    input  logic [7:0]                        i_cell_y,
    // result
    output logic                              o_done,
    output logic [7:0]                        o_ant_x,
    output logic [7:0]                        o_ant_y,
    output logic [1:0]                        o_heading,
    output logic [mcant_pkg::COLOR_W-1:0]     o_cell_color,
    output logic                              o_halted,
    output logic [mcant_pkg::COUNT_W-1:0]     o_move_count,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mcant_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mcant_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import mcant_pkg::*;

    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam int ADDR_W = 2 * POS_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // Clamp a raw grid size to the supported range
    function automatic logic [DIM_W-1:0] f_clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext < CMP_W'(DIM_MIN)) begin
            return DIM_W'(DIM_MIN);
        end else if (ext > CMP_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(ext);
        end
    endfunction

    // Centre coordinate for a raw grid size
    function automatic logic [POS_W-1:0] f_centre(input logic [CFG_DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = f_clamp_dim(v);
        return POS_W'(d >> 1);
    endfunction

    // Control and state registers
    logic [1:0]             r_state,      n_state;
    logic [ADDR_W-1:0]      r_clr_addr,   n_clr_addr;
    logic [CFG_DIM_W-1:0]   r_grid_w,     n_grid_w;
    logic [CFG_DIM_W-1:0]   r_grid_h,     n_grid_h;
    logic [CFG_CNT_W-1:0]   r_color_cnt,  n_color_cnt;
    logic [CFG_RULE_W-1:0]  r_turn_rules, n_turn_rules;
    logic [POS_W-1:0]       r_pos_x,      n_pos_x;
    logic [POS_W-1:0]       r_pos_y,      n_pos_y;
    t_heading               r_dir,        n_dir;
    logic                   r_stopped,    n_stopped;
    logic [COUNT_W-1:0]     r_steps,      n_steps;
    logic                   r_done,       n_done;

    // Payload registers
    logic                   r_op,         n_op;
    logic                   r_rd_inside,  n_rd_inside;
    logic [COLOR_W-1:0]     r_color,      n_color;

    // Memory interface
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [COLOR_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [COLOR_W-1:0]     ram_rdata;

    // Derived step values
    logic [DIM_W-1:0]       eff_w;
    logic [DIM_W-1:0]       eff_h;
    logic [CFG_CNT_W-1:0]   eff_colors;
    logic [1:0]             turn;
    t_heading               step_dir;
    logic [CFG_CNT_W-1:0]   color_inc;
    logic [COLOR_W-1:0]     next_color;
    logic [DIM_W-1:0]       x_inc;
    logic [DIM_W-1:0]       y_inc;

    assign eff_w = f_clamp_dim(r_grid_w);
    assign eff_h = f_clamp_dim(r_grid_h);

    // Colour count clamped to [2, 16]
    always_comb begin
        if (r_color_cnt < CFG_CNT_W'(COLORS_MIN)) begin
            eff_colors = CFG_CNT_W'(COLORS_MIN);
        end else if (r_color_cnt > CFG_CNT_W'(MAX_COLORS)) begin
            eff_colors = CFG_CNT_W'(MAX_COLORS);
        end else begin
            eff_colors = r_color_cnt;
        end
    end

    // Turn, new heading and next colour from the cell under the ant
    assign turn       = r_turn_rules[{ram_rdata, 1'b0} +: 2];
    assign step_dir   = r_dir + turn;
    assign color_inc  = CFG_CNT_W'(ram_rdata) + CFG_CNT_W'(1);
    assign next_color = (color_inc >= eff_colors) ? '0 : COLOR_W'(color_inc);
    assign x_inc      = DIM_W'(r_pos_x) + DIM_W'(1);
    assign y_inc      = DIM_W'(r_pos_y) + DIM_W'(1);

    mcant_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (COLOR_W)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: clear pass, accept, read-modify-write
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_grid_w     = r_grid_w;
        n_grid_h     = r_grid_h;
        n_color_cnt  = r_color_cnt;
        n_turn_rules = r_turn_rules;
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_dir        = r_dir;
        n_stopped    = r_stopped;
        n_steps      = r_steps;
        n_done       = 1'b0;
        n_op         = r_op;
        n_rd_inside  = r_rd_inside;
        n_color      = r_color;
        ram_we       = 1'b0;
        ram_waddr    = {r_pos_y, r_pos_x};
        ram_wdata    = next_color;
        ram_raddr    = {r_pos_y, r_pos_x};

        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == {ADDR_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_operation == OP_READ) begin
                    ram_raddr = {POS_W'(i_cell_y), POS_W'(i_cell_x)};
                end
                if (i_start) begin
                    n_state     = ST_EXEC;
                    n_op        = i_operation;
                    n_rd_inside = (CMP_W'(i_cell_x) < CMP_W'(eff_w)) &&
                                  (CMP_W'(i_cell_y) < CMP_W'(eff_h));
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (r_op == OP_READ) begin
                    n_color = r_rd_inside ? ram_rdata : '0;
                end else if (r_stopped) begin
                    n_color = ram_rdata;
                end else begin
                    ram_we  = 1'b1;
                    n_color = next_color;
                    n_dir   = step_dir;
                    if (r_steps != {COUNT_W{1'b1}}) begin
                        n_steps = r_steps + COUNT_W'(1);
                    end
                    // Move, or halt at the edge
                    unique case (step_dir)
                        HEAD_UP: begin
                            if (r_pos_y == '0) n_stopped = 1'b1;
                            else n_pos_y = r_pos_y - POS_W'(1);
                        end
                        HEAD_RIGHT: begin
                            if (x_inc >= eff_w) n_stopped = 1'b1;
                            else n_pos_x = POS_W'(x_inc);
                        end
                        HEAD_DOWN: begin
                            if (y_inc >= eff_h) n_stopped = 1'b1;
                            else n_pos_y = POS_W'(y_inc);
                        end
                        default: begin
                            if (r_pos_x == '0) n_stopped = 1'b1;
                            else n_pos_x = r_pos_x - POS_W'(1);
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Configuration transfer
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH: begin
                    n_grid_w = i_cfg_data[CFG_DIM_W-1:0];
                    n_pos_x  = f_centre(i_cfg_data[CFG_DIM_W-1:0]);
                end
                CFG_GRID_HEIGHT: begin
                    n_grid_h = i_cfg_data[CFG_DIM_W-1:0];
                    n_pos_y  = f_centre(i_cfg_data[CFG_DIM_W-1:0]);
                end
                CFG_COLOR_COUNT: n_color_cnt  = i_cfg_data[CFG_CNT_W-1:0];
                CFG_TURN_RULES:  n_turn_rules = i_cfg_data[CFG_RULE_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_grid_w     <= GRID_W_RST;
            r_grid_h     <= GRID_H_RST;
            r_color_cnt  <= COLOR_CNT_RST;
            r_turn_rules <= TURN_RULES_RST;
            r_pos_x      <= f_centre(GRID_W_RST);
            r_pos_y      <= f_centre(GRID_H_RST);
            r_dir        <= HEAD_UP;
            r_stopped    <= 1'b0;
            r_steps      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_grid_w     <= n_grid_w;
            r_grid_h     <= n_grid_h;
            r_color_cnt  <= n_color_cnt;
            r_turn_rules <= n_turn_rules;
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_dir        <= n_dir;
            r_stopped    <= n_stopped;
            r_steps      <= n_steps;
            r_done       <= n_done;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_rd_inside <= n_rd_inside;
        r_color     <= n_color;
    end

    // Outputs
    assign o_busy       = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_ant_x      = 8'(r_pos_x);
    assign o_ant_y      = 8'(r_pos_y);
    assign o_heading    = r_dir;
    assign o_cell_color = r_color;
    assign o_halted     = r_stopped;
    assign o_move_count = r_steps;

endmodule
